FILE: rtl/hmr_pkg.sv
// Package for the handshake message receiver: payload types, codes and reset constants.
`default_nettype none

package hmr_pkg;

	// Input operation codes
	localparam logic OP_WORD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result status codes
	localparam logic [2:0] ST_NONE    = 3'd0;
	localparam logic [2:0] ST_REQ_OK  = 3'd1;
	localparam logic [2:0] ST_MSG     = 3'd2;
	localparam logic [2:0] ST_DONE    = 3'd3;
	localparam logic [2:0] ST_INVALID = 3'd4;
	localparam logic [2:0] ST_TIMEOUT = 3'd5;
	localparam logic [2:0] ST_DROPPED = 3'd6;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_REQ    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_FIRST  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_NEXT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration reset values
	localparam logic [7:0]  RST_OWN_ADDRESS = 8'd1;
	localparam logic [7:0]  RST_TYPE_REQ    = 8'd1;
	localparam logic [7:0]  RST_TYPE_FIRST  = 8'd3;
	localparam logic [7:0]  RST_TYPE_NEXT   = 8'd4;
	localparam logic [15:0] RST_TIMEOUT     = 16'd1000;

	// Most results one input can cause
	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic        op;
		logic [31:0] word;
	} hmr_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  ack_address;
		logic [15:0] ack_sequence;
		logic        byte_valid;
		logic [7:0]  byte_value;
		logic [7:0]  byte_index;
		logic        last;
	} hmr_out_t;

	typedef struct packed {
		logic [7:0]  own_address;
		logic [7:0]  type_request;
		logic [7:0]  type_message_first;
		logic [7:0]  type_message_next;
		logic [15:0] message_timeout_ms;
	} hmr_cfg_t;

	// Results of one processed input, slot 0 first
	typedef struct packed {
		logic [1:0]                   count;
		hmr_out_t [MAX_RESULTS-1:0]   slot;
	} hmr_bundle_t;

	// Protocol state
	typedef struct packed {
		logic        phase;
		logic        holding;
		logic [31:0] first_half;
		logic [7:0]  requester;
		logic        second_of_pair;
		logic [7:0]  held_one;
		logic [7:0]  held_two;
		logic [7:0]  write_pos;
		logic [15:0] silence;
	} hmr_state_t;

endpackage

`default_nettype wire

FILE: rtl/hmr_proto.sv
// Receiver protocol state and the single-pass evaluation of one request.
`default_nettype none

module hmr_proto #(
	parameter int MESSAGE_BYTES = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire hmr_pkg::hmr_in_t  item_s1,
	input  wire hmr_pkg::hmr_cfg_t cfg,
	output hmr_pkg::hmr_bundle_t   bundle
);
	import hmr_pkg::*;

	localparam logic [8:0] MB9 = 9'(MESSAGE_BYTES);

	hmr_state_t st_q;
	hmr_state_t st_n;

	// State register, advanced once per processed request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
			st_q.requester <= RST_OWN_ADDRESS;
		end else if (fire) begin
			st_q <= st_n;
		end
	end

	// Next state and results
	always_comb begin
		logic [31:0]   f;
		logic [31:0]   w;
		logic [7:0]    expect_type;
		logic [7:0]    sum;
		logic          ok;
		logic [11:0]   pay;
		logic [15:0]   timer;
		logic [2:0][7:0] bb;
		logic [8:0]    pos;
		logic [1:0]    cnt;
		logic [7:0]    wpos_n;

		st_n   = st_q;
		bundle = '0;
		f      = st_q.first_half;
		w      = item_s1.word;
		cnt    = 2'd0;
		pos    = '0;
		wpos_n = st_q.write_pos;
		pay    = w[19:8];
		bb[0]  = st_q.held_one;
		bb[1]  = st_q.held_two | {4'h0, pay[11:8]};
		bb[2]  = pay[7:0];
		timer  = (st_q.silence == 16'hffff) ? st_q.silence : st_q.silence + 16'd1;
		sum    = f[7:0] + f[15:8] + f[23:16] + f[31:24]
		       + w[7:0] + w[15:8] + w[23:16] + w[31:24];
		ok     = (sum == 8'h00);

		if (!st_q.phase)
			expect_type = cfg.type_request;
		else if (st_q.write_pos == 8'd0 && !st_q.second_of_pair)
			expect_type = cfg.type_message_first;
		else
			expect_type = cfg.type_message_next;

		if (item_s1.op == OP_TICK) begin
			// Silence timer runs only in the message phase
			if (st_q.phase) begin
				st_n.silence = timer;
				if (timer >= cfg.message_timeout_ms) begin
					st_n.phase   = 1'b0;
					st_n.holding = 1'b0;
					bundle.slot[0].status = ST_TIMEOUT;
					cnt = 2'd1;
				end
			end
		end else if (!st_q.holding) begin
			// First half: type check only
			if (w[31:24] != expect_type) begin
				bundle.slot[0].status = ST_DROPPED;
				cnt = 2'd1;
			end else begin
				st_n.first_half = w;
				st_n.holding    = 1'b1;
			end
		end else begin
			st_n.holding = 1'b0;
			if (!st_q.phase) begin
				// Request packet
				if (ok && w[31:24] == 8'h00) begin
					st_n.requester      = f[7:0];
					st_n.phase          = 1'b1;
					st_n.silence        = '0;
					st_n.write_pos      = '0;
					st_n.second_of_pair = 1'b0;
					bundle.slot[0].status       = ST_REQ_OK;
					bundle.slot[0].ack_address  = f[7:0];
					bundle.slot[0].ack_sequence = f[23:8] + 16'd1;
				end else begin
					bundle.slot[0].status = ST_INVALID;
				end
				cnt = 2'd1;
			end else if (!ok || w[31:24] != cfg.own_address || f[7:0] != st_q.requester) begin
				st_n.phase = 1'b0;
				bundle.slot[0].status = ST_INVALID;
				cnt = 2'd1;
			end else begin
				st_n.silence = '0;
				if (!st_q.second_of_pair) begin
					// First packet of a pair: hold 12 payload bits
					st_n.held_one       = pay[11:4];
					st_n.held_two       = {pay[3:0], 4'h0};
					st_n.second_of_pair = 1'b1;
					bundle.slot[0].status = ST_MSG;
					cnt = 2'd1;
				end else begin
					// Second packet: up to three bytes, clipped at the message end
					st_n.second_of_pair = 1'b0;
					for (int i = 0; i < MAX_RESULTS; i++) begin
						pos = {1'b0, st_q.write_pos} + 9'(i);
						if (pos < MB9) begin
							bundle.slot[i].status     = (pos + 9'd1 == MB9) ? ST_DONE : ST_MSG;
							bundle.slot[i].byte_valid = 1'b1;
							bundle.slot[i].byte_value = bb[i];
							bundle.slot[i].byte_index = pos[7:0];
							cnt = cnt + 2'd1;
						end
					end
					wpos_n = st_q.write_pos + {6'd0, cnt};
					st_n.write_pos = wpos_n;
					if ({1'b0, wpos_n} >= MB9)
						st_n.phase = 1'b0;
					if (cnt == 2'd0) begin
						bundle.slot[0].status = ST_MSG;
						cnt = 2'd1;
					end
				end
			end
		end

		// Mark the final result
		for (int i = 0; i < MAX_RESULTS; i++)
			bundle.slot[i].last = (cnt != 2'd0) && (2'(i) == cnt - 2'd1);
		bundle.count = cnt;
	end

endmodule

`default_nettype wire

FILE: rtl/hmr_ser.sv
// Result buffer: holds the results of one request and hands them out one per cycle while result_ready is high.
`default_nettype none

module hmr_ser (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 load,
	input  wire hmr_pkg::hmr_bundle_t bundle,
	output logic                      free,
	output logic                      result_valid,
	input  wire logic                 result_ready,
	output hmr_pkg::hmr_out_t         result
);
	import hmr_pkg::*;

	hmr_out_t [MAX_RESULTS-1:0] slot_q;
	logic [1:0]                 cnt_q;
	logic [1:0]                 ptr_q;
	logic                       take_last;

	assign result_valid = (cnt_q != 2'd0);
	assign result       = slot_q[ptr_q];
	assign take_last    = result_valid && result_ready && (ptr_q == cnt_q - 2'd1);
	assign free         = !result_valid || take_last;

	// Payload slots
	always_ff @(posedge clk) begin
		if (load)
			slot_q <= bundle.slot;
	end

	// Count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			ptr_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bundle.count;
			ptr_q <= 2'd0;
		end else if (take_last) begin
			cnt_q <= 2'd0;
			ptr_q <= 2'd0;
		end else if (result_valid && result_ready) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/handshake_message_receiver_core.sv
// Top level of the handshake message receiver.
//
// Input channel item_valid/item_ready/item carries transport words (op 0) and
// millisecond ticks (op 1). Words pair up into 8-byte packets; the receiver
// checks requests, tracks the message window and reassembles message bytes.
// Output channel result_valid/result_ready/result carries zero to three
// results per request; the last one of a request has result.last set.
// Configuration registers are written through cfg_we/cfg_addr/cfg_wdata; the user
// must write them only while the block is idle, which the block does not enforce.
// A request accepted into the input register is evaluated once the result
// buffer is free, and its first result is valid right after that evaluation.
// Throughput: one request per cycle while each causes at most one result and
// result_ready is high; the result buffer hands out one result per cycle while
// result_ready is high, so extra results hold the evaluation stage until taken.
// When the receiver stalls, results wait in the buffer, one request waits in
// the input register, and item_ready drops.
// Reset clears the protocol to waiting for a request and loads the register
// defaults; no result is pending after reset.
`default_nettype none

module handshake_message_receiver_core #(
	parameter int MESSAGE_BYTES = 24
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               item_valid,
	output logic                                    item_ready,
	input  wire hmr_pkg::hmr_in_t                   item,
	output logic                                    result_valid,
	input  wire logic                               result_ready,
	output hmr_pkg::hmr_out_t                       result,
	input  wire logic                               cfg_we,
	input  wire logic [hmr_pkg::CFG_IDX_W-1:0]      cfg_addr,
	input  wire logic [hmr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import hmr_pkg::*;

	hmr_cfg_t    cfg_q;
	hmr_in_t     item_s1;
	logic        valid_s1;
	logic        fire;
	logic        ser_free;
	hmr_bundle_t bundle;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.own_address        <= RST_OWN_ADDRESS;
			cfg_q.type_request       <= RST_TYPE_REQ;
			cfg_q.type_message_first <= RST_TYPE_FIRST;
			cfg_q.type_message_next  <= RST_TYPE_NEXT;
			cfg_q.message_timeout_ms <= RST_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_OWN_ADDRESS: cfg_q.own_address        <= cfg_wdata[7:0];
				CFG_TYPE_REQ:    cfg_q.type_request       <= cfg_wdata[7:0];
				CFG_TYPE_FIRST:  cfg_q.type_message_first <= cfg_wdata[7:0];
				CFG_TYPE_NEXT:   cfg_q.type_message_next  <= cfg_wdata[7:0];
				CFG_TIMEOUT:     cfg_q.message_timeout_ms <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register; evaluated when the result buffer can take its results
	assign fire       = valid_s1 && ser_free;
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (item_ready)
			valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	hmr_proto #(
		.MESSAGE_BYTES(MESSAGE_BYTES)
	) u_proto (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.bundle  (bundle)
	);

	hmr_ser u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.bundle       (bundle),
		.free         (ser_free),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

FILE: rtl/hmr_checker.sv
// Port-level checks for the handshake message receiver, bound to the top level.
`default_nettype none

module hmr_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire hmr_pkg::hmr_out_t result
);
	import hmr_pkg::*;

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result changed");

	// Every delivered result carries a real status
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status != ST_NONE && result.status <= ST_DROPPED)
		else $error("result with no status");

	// Message bytes only come with message statuses
	a_byte: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.byte_valid |->
			result.status == ST_MSG || result.status == ST_DONE)
		else $error("byte with wrong status");

	// Message completion is the final byte of its request
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_DONE |-> result.last && result.byte_valid)
		else $error("completion not last byte");

	// A request acceptance stands alone
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == ST_REQ_OK |-> result.last && !result.byte_valid)
		else $error("request acceptance malformed");

endmodule

bind handshake_message_receiver_core hmr_checker u_hmr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

`default_nettype wire

FILE: dv/tb_top.sv
// Testbench for handshake_message_receiver_core: directed table, random sessions, result checks.
module tb_top;
	import hmr_pkg::*;

	localparam int MSG_BYTES = 24;
	localparam int HOLD_CYCLES = 40;
	localparam int PREDICTED = -1;
	localparam int ITEMS_PER_PHASE = 66;

	typedef enum logic [1:0] {ROW_WORD, ROW_TICK, ROW_CFG} row_kind_e;
	typedef enum logic {AWAIT_REQUEST, IN_MESSAGE} rx_phase_e;
	typedef enum int {FAULT_NONE, FAULT_SUM, FAULT_TYPE, FAULT_DST, FAULT_SRC} fault_e;

	// one directed request; for ROW_CFG word[18:16] is the register, word[15:0] the data
	typedef struct {
		row_kind_e   kind;
		logic [31:0] word;
		int          n_want;
		logic [2:0]  status;
		logic [7:0]  ack_address;
		logic [15:0] ack_sequence;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	hmr_in_t              item = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	hmr_out_t             result;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// shadow copy of the receiver
	hmr_cfg_t   regs;
	rx_phase_e  rx_phase;
	logic       holding;
	logic [31:0] half_word;
	logic [7:0] requester;
	logic       pair_second;
	logic [7:0] held_one;
	logic [7:0] held_two;
	logic [7:0] wr_pos;
	logic [15:0] silence;

	hmr_out_t step_out[$];
	hmr_out_t pending[$];
	hmr_out_t want;
	dir_row_t dir_rows[$];

	int  fail_count = 0;
	int  items_sent = 0;
	int  phases_run = 0;
	int  status_seen [0:7] = '{default: 0};
	int  hold_asks = 0;
	int  hold_seen = 0;
	bit  tx_idle_on = 1'b1;
	bit  rx_idle_on = 1'b1;

	handshake_message_receiver_core #(.MESSAGE_BYTES(MSG_BYTES)) DUT (
		.clk, .arst_n, .item_valid, .item_ready, .item, .result_valid, .result_ready,
		.result, .cfg_we, .cfg_addr, .cfg_wdata
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#400000;
		$display("tb_top failed");
		$finish;
	end

	// byte sum of a packet, mod 256
	function automatic logic [7:0] byte_total(logic [31:0] a, logic [31:0] b);
		logic [7:0] s = 8'h00;
		for (int i = 0; i < 4; i++) s += a[8*i +: 8] + b[8*i +: 8];
		return s;
	endfunction

	// fill the check byte so the packet sums to zero
	function automatic logic [31:0] close_packet(logic [31:0] first, logic [31:0] second);
		return {second[31:8], 8'(8'h00 - byte_total(first, {second[31:8], 8'h00}))};
	endfunction

	function automatic void reset_receiver();
		regs = '{own_address: RST_OWN_ADDRESS, type_request: RST_TYPE_REQ,
			type_message_first: RST_TYPE_FIRST, type_message_next: RST_TYPE_NEXT,
			message_timeout_ms: RST_TIMEOUT};
		rx_phase = AWAIT_REQUEST;
		holding = 1'b0;
		half_word = '0;
		requester = RST_OWN_ADDRESS;
		pair_second = 1'b0;
		held_one = '0;
		held_two = '0;
		wr_pos = '0;
		silence = '0;
	endfunction

	function automatic void add_result(logic [2:0] st, logic [7:0] a, logic [15:0] s,
			logic bv, logic [7:0] v, logic [7:0] idx);
		step_out.push_back('{status: st, ack_address: a, ack_sequence: s, byte_valid: bv,
			byte_value: v, byte_index: idx, last: 1'b0});
	endfunction

	// results that one request causes; updates the shadow state
	function automatic void step_receiver(hmr_in_t it);
		logic [7:0] want_type;
		logic [7:0] src;
		logic [7:0] dst;
		logic [15:0] seq;
		logic [11:0] pay;
		logic [7:0] b [3];
		logic ok;
		step_out.delete();
		if (it.op == OP_TICK) begin
			if (rx_phase == IN_MESSAGE) begin
				if (silence != 16'hFFFF) silence++;
				if (silence >= regs.message_timeout_ms) begin
					rx_phase = AWAIT_REQUEST;
					holding = 1'b0;
					add_result(ST_TIMEOUT, 0, 0, 0, 0, 0);
				end
			end
		end else if (!holding) begin
			if (rx_phase == AWAIT_REQUEST) want_type = regs.type_request;
			else if (wr_pos == 0 && !pair_second) want_type = regs.type_message_first;
			else want_type = regs.type_message_next;
			if (it.word[31:24] != want_type) begin
				add_result(ST_DROPPED, 0, 0, 0, 0, 0);
			end else begin
				half_word = it.word;
				holding = 1'b1;
			end
		end else begin
			src = half_word[7:0];
			dst = it.word[31:24];
			seq = half_word[23:8];
			ok = byte_total(half_word, it.word) == 8'h00;
			holding = 1'b0;
			if (rx_phase == AWAIT_REQUEST) begin
				if (ok && dst == 8'h00) begin
					requester = src;
					rx_phase = IN_MESSAGE;
					silence = '0;
					wr_pos = '0;
					pair_second = 1'b0;
					add_result(ST_REQ_OK, src, seq + 16'd1, 0, 0, 0);
				end else begin
					add_result(ST_INVALID, 0, 0, 0, 0, 0);
				end
			end else if (!ok || dst != regs.own_address || src != requester) begin
				rx_phase = AWAIT_REQUEST;
				add_result(ST_INVALID, 0, 0, 0, 0, 0);
			end else begin
				pay = it.word[19:8];
				silence = '0;
				if (!pair_second) begin
					// first of a pair: keep 12 bits, no byte yet
					held_one = pay[11:4];
					held_two = {pay[3:0], 4'h0};
					pair_second = 1'b1;
					add_result(ST_MSG, 0, 0, 0, 0, 0);
				end else begin
					b[0] = held_one;
					b[1] = held_two | {4'h0, pay[11:8]};
					b[2] = pay[7:0];
					pair_second = 1'b0;
					for (int i = 0; i < 3; i++) begin
						if (wr_pos < MSG_BYTES) begin
							wr_pos++;
							add_result((wr_pos == MSG_BYTES) ? ST_DONE : ST_MSG, 0, 0, 1'b1,
								b[i], wr_pos - 8'd1);
						end
					end
					if (wr_pos >= MSG_BYTES) rx_phase = AWAIT_REQUEST;
					if (step_out.size() == 0) add_result(ST_MSG, 0, 0, 0, 0, 0);
				end
			end
		end
		if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	// result checker
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			status_seen[result.status]++;
			if (pending.size() == 0) begin
				$error("status: expected no result, got %0d", result.status);
				fail_count++;
			end else begin
				want = pending.pop_front();
				check_field("status", 32'(want.status), 32'(result.status));
				check_field("ack_address", 32'(want.ack_address), 32'(result.ack_address));
				check_field("ack_sequence", 32'(want.ack_sequence), 32'(result.ack_sequence));
				check_field("byte_valid", 32'(want.byte_valid), 32'(result.byte_valid));
				check_field("byte_value", 32'(want.byte_value), 32'(result.byte_value));
				check_field("byte_index", 32'(want.byte_index), 32'(result.byte_index));
				check_field("last", 32'(want.last), 32'(result.last));
			end
		end
	end

	// result side: random stalls, plus a long hold-off when asked
	initial begin : receiver
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = 0;
			if (hold_asks != 0 && receiver.gap == 0 && hold_seen < hold_asks) begin
				hold_seen++;
				gap = HOLD_CYCLES;
			end else if (rx_idle_on) begin
				gap = $urandom_range(0, 3);
			end
			if (gap > 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
		end
	end

	// offer one request and wait for its acceptance
	task automatic send_item(hmr_in_t it);
		int gap;
		gap = tx_idle_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		items_sent++;
	endtask

	task automatic apply(hmr_in_t it);
		send_item(it);
		step_receiver(it);
		foreach (step_out[k]) pending.push_back(step_out[k]);
	endtask

	task automatic apply_tick();
		hmr_in_t it;
		it.op = OP_TICK;
		it.word = $urandom;
		apply(it);
	endtask

	task automatic apply_word(logic [31:0] w);
		hmr_in_t it;
		it.op = OP_WORD;
		it.word = w;
		apply(it);
	endtask

	// wait until the block is idle
	task automatic settle();
		item_valid <= 1'b0;
		for (int i = 0; i < 5000 && pending.size() != 0; i++) @(posedge clk);
		if (pending.size() != 0) begin
			$error("status: %0d results never arrived", pending.size());
			fail_count++;
			pending.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			CFG_OWN_ADDRESS: regs.own_address = data[7:0];
			CFG_TYPE_REQ:    regs.type_request = data[7:0];
			CFG_TYPE_FIRST:  regs.type_message_first = data[7:0];
			CFG_TYPE_NEXT:   regs.type_message_next = data[7:0];
			CFG_TIMEOUT:     regs.message_timeout_ms = data;
			default: ;
		endcase
	endtask

	task automatic write_regs(hmr_cfg_t c);
		settle();
		write_reg(CFG_OWN_ADDRESS, 16'(c.own_address));
		write_reg(CFG_TYPE_REQ, 16'(c.type_request));
		write_reg(CFG_TYPE_FIRST, 16'(c.type_message_first));
		write_reg(CFG_TYPE_NEXT, 16'(c.type_message_next));
		write_reg(CFG_TIMEOUT, c.message_timeout_ms);
		cfg_we <= 1'b0;
	endtask

	function automatic fault_e pick_fault(int pct);
		if ($urandom_range(0, 99) < pct) return fault_e'($urandom_range(1, 4));
		return FAULT_NONE;
	endfunction

	// one packet with random sequence and payload, optionally broken
	task automatic drive_packet(logic [7:0] ptype, logic [7:0] src, logic [7:0] dst,
			fault_e fault);
		logic [31:0] first;
		logic [31:0] second;
		first = {ptype, 16'($urandom), src};
		second = {dst, 16'($urandom), 8'h00};
		case (fault)
			FAULT_TYPE: first[31:24] ^= 8'($urandom_range(1, 255));
			FAULT_SRC:  first[7:0] ^= 8'($urandom_range(1, 255));
			FAULT_DST:  second[31:24] ^= 8'($urandom_range(1, 255));
			default: ;
		endcase
		second = close_packet(first, second);
		if (fault == FAULT_SUM) second[7:0] += 8'($urandom_range(1, 255));
		apply_word(first);
		if ($urandom_range(0, 99) < 3) apply_tick();
		apply_word(second);
	endtask

	// a request followed by a full or partial message
	task automatic random_session();
		logic [7:0] who;
		int npkt;
		who = 8'($urandom);
		drive_packet(regs.type_request, who, 8'h00, pick_fault(10));
		npkt = ($urandom_range(0, 9) < 6) ? 2 * MSG_BYTES / 3 :
			$urandom_range(1, 2 * MSG_BYTES / 3);
		for (int k = 0; k < npkt; k++) begin
			if ($urandom_range(0, 99) < 6) repeat ($urandom_range(1, 2)) apply_tick();
			drive_packet((k == 0) ? regs.type_message_first : regs.type_message_next, who,
				regs.own_address, pick_fault(4));
		end
	endtask

	function automatic hmr_cfg_t rand_cfg(logic [15:0] tmo);
		return '{own_address: 8'($urandom_range(1, 255)), type_request: 8'($urandom),
			type_message_first: 8'($urandom), type_message_next: 8'($urandom),
			message_timeout_ms: tmo};
	endfunction

	task automatic run_phase(hmr_cfg_t c, bit tx_idle, bit rx_idle, bit hold);
		int goal;
		int pick;
		bit asked;
		hmr_in_t it;
		asked = 1'b0;
		write_regs(c);
		tx_idle_on = tx_idle;
		rx_idle_on = rx_idle;
		phases_run++;
		goal = items_sent + ITEMS_PER_PHASE;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				it.op = 1'($urandom_range(0, 1));
				it.word = $urandom;
				apply(it);
			end else if (pick < 14) begin
				repeat ($urandom_range(1, 3)) apply_tick();
			end else begin
				random_session();
			end
			if (hold && !asked) begin
				hold_asks <= hold_asks + 1;
				asked = 1'b1;
			end
		end
	endtask

	function automatic dir_row_t drow(row_kind_e kind, logic [31:0] w, int n,
			logic [2:0] st = ST_NONE, logic [7:0] a = 8'h00, logic [15:0] s = 16'h0000);
		return '{kind: kind, word: w, n_want: n, status: st, ack_address: a, ack_sequence: s};
	endfunction

	initial begin : stimulus
		dir_row_t r;
		hmr_in_t it;
		logic [31:0] f;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reset_receiver();

		// directed table under reset settings
		dir_rows.push_back(drow(ROW_TICK, 32'hFFFF_FFFF, 0));
		dir_rows.push_back(drow(ROW_WORD, 32'h0000_0000, 1, ST_DROPPED));
		dir_rows.push_back(drow(ROW_WORD, 32'hFFFF_FFFF, 1, ST_DROPPED));
		// request with sequence wrapping to zero
		f = {RST_TYPE_REQ, 16'hFFFF, 8'hFF};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, 32'h00AB_C000), 1, ST_REQ_OK,
			8'hFF, 16'h0000));
		// wrong type for the first message packet
		dir_rows.push_back(drow(ROW_WORD, {RST_TYPE_NEXT, 16'h0001, 8'hFF}, 1, ST_DROPPED));
		f = {RST_TYPE_FIRST, 16'h0001, 8'hFF};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, {RST_OWN_ADDRESS, 24'hFFFF00}), 1,
			ST_MSG));
		f = {RST_TYPE_NEXT, 16'h0002, 8'hFF};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, {RST_OWN_ADDRESS, 24'hF00000}),
			PREDICTED));
		// bad check byte ends the message
		f = {RST_TYPE_NEXT, 16'h0003, 8'hFF};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, {RST_OWN_ADDRESS, 24'h123400}) ^ 32'h1,
			1, ST_INVALID));
		// request to a nonzero destination
		f = {RST_TYPE_REQ, 16'h1234, 8'h00};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, 32'h8000_0000), 1, ST_INVALID));
		f = {RST_TYPE_REQ, 16'h0000, 8'h00};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, 32'h0000_0000), 1, ST_REQ_OK,
			8'h00, 16'h0001));
		// message from someone other than the requester
		f = {RST_TYPE_FIRST, 16'h0001, 8'h05};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, {RST_OWN_ADDRESS, 24'h0}), 1,
			ST_INVALID));
		f = {RST_TYPE_REQ, 16'h7FFF, 8'h42};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, 32'h0000_0000), 1, ST_REQ_OK,
			8'h42, 16'h8000));
		// message to another node
		f = {RST_TYPE_FIRST, 16'h8000, 8'h42};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, 32'h0200_0000), 1, ST_INVALID));
		// timeout of two ticks, with a half packet held
		dir_rows.push_back(drow(ROW_CFG, {13'd0, CFG_TIMEOUT, 16'd2}, 0));
		f = {RST_TYPE_REQ, 16'hABCD, 8'h42};
		dir_rows.push_back(drow(ROW_WORD, f, 0));
		dir_rows.push_back(drow(ROW_WORD, close_packet(f, 32'h0000_0000), 1, ST_REQ_OK,
			8'h42, 16'hABCE));
		dir_rows.push_back(drow(ROW_WORD, {RST_TYPE_FIRST, 16'hABCE, 8'h42}, 0));
		dir_rows.push_back(drow(ROW_TICK, 32'h0000_0000, 0));
		dir_rows.push_back(drow(ROW_TICK, 32'h0000_0000, 1, ST_TIMEOUT));

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.kind == ROW_CFG) begin
				settle();
				write_reg(r.word[18:16], r.word[15:0]);
				cfg_we <= 1'b0;
			end else begin
				it.op = (r.kind == ROW_TICK) ? OP_TICK : OP_WORD;
				it.word = r.word;
				send_item(it);
				step_receiver(it);
				if (r.n_want == PREDICTED) begin
					foreach (step_out[k]) pending.push_back(step_out[k]);
				end else if (r.n_want == 1) begin
					pending.push_back('{status: r.status, ack_address: r.ack_address,
						ack_sequence: r.ack_sequence, byte_valid: 1'b0, byte_value: 8'h00,
						byte_index: 8'h00, last: 1'b1});
				end
			end
		end

		// random sessions over several register settings
		run_phase('{own_address: 8'hFF, type_request: 8'h00, type_message_first: 8'hFF,
			type_message_next: 8'h80, message_timeout_ms: 16'd1}, 1'b1, 1'b1, 1'b0);
		run_phase(rand_cfg(16'hFFFF), 1'b0, 1'b0, 1'b1);
		run_phase(rand_cfg(16'h0000), 1'b1, 1'b0, 1'b0);
		run_phase('{own_address: 8'h01, type_request: 8'hFF, type_message_first: 8'h00,
			type_message_next: 8'h7F, message_timeout_ms: 16'($urandom_range(2, 20))},
			1'b0, 1'b1, 1'b1);
		run_phase(rand_cfg(16'd3), 1'b1, 1'b1, 1'b0);

		settle();
		repeat (16) @(posedge clk);
		$display("Ran %0d requests over %0d register settings plus the directed table.",
			items_sent, phases_run);
		$display("Results: %0d accepted REQ, %0d message, %0d complete,",
			status_seen[ST_REQ_OK], status_seen[ST_MSG], status_seen[ST_DONE]);
		$display("         %0d invalid, %0d timeout, %0d dropped.",
			status_seen[ST_INVALID], status_seen[ST_TIMEOUT], status_seen[ST_DROPPED]);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

FILE: files.f
rtl/hmr_pkg.sv
rtl/hmr_proto.sv
rtl/hmr_ser.sv
rtl/handshake_message_receiver_core.sv
rtl/hmr_checker.sv
dv/tb_top.sv
